FILE: hdl/page_range_permission_checker_unit_assert.svh
//------------------------------------------------------------------------------
// page_range_permission_checker_unit assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
//------------------------------------------------------------------------------
`ifndef PAGE_RANGE_PERMISSION_CHECKER_UNIT_ASSERT_SVH
`define PAGE_RANGE_PERMISSION_CHECKER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define PRPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("prpc assertion failed");
// antecedent implies consequent in the next cycle
`define PRPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("prpc assertion failed");
`else
`define PRPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PRPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/prpc_pkg.sv
//------------------------------------------------------------------------------
// prpc_pkg
// Shared widths, codes, state type and control structs of the range checker.
//------------------------------------------------------------------------------
package prpc_pkg;

	localparam int TABLE_ENTRIES_DEF = 128;
	localparam int PAGE_SHIFT_DEF    = 13;

	localparam int ADDR_W   = 32;
	localparam int LEN_W    = 31;
	localparam int BASE_W   = 19;
	localparam int PROT_W   = 3;
	localparam int EIDX_W   = 7;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_DRAIN,
		ST_RESULT
	} prpc_state_t;

	// controller -> datapath
	typedef struct packed {
		logic req_ready;
		logic wr_entry;
		logic cap;
		logic setup;
		logic issue;
		logic clr_ok;
		logic out_load;
	} prpc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic req_valid;
		logic req_check;
		logic over;
		logic rem_zero;
		logic fail;
		logic out_free;
	} prpc_stat_t;

endpackage

FILE: hdl/prpc_req_if.sv
//------------------------------------------------------------------------------
// prpc_req_if
// Request channel: table write or range check.
//------------------------------------------------------------------------------
interface prpc_req_if import prpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [EIDX_W-1:0] entry_index;
	logic              entry_valid;
	logic [PROT_W-1:0] entry_prot;
	logic [ADDR_W-1:0] start_address;
	logic [LEN_W-1:0]  byte_length;
	logic [PROT_W-1:0] required_prot;

	modport source (
		output valid, opcode, entry_index, entry_valid, entry_prot,
			start_address, byte_length, required_prot,
		input  ready
	);
	modport sink (
		input  valid, opcode, entry_index, entry_valid, entry_prot,
			start_address, byte_length, required_prot,
		output ready
	);
endinterface

FILE: hdl/prpc_rsp_if.sv
//------------------------------------------------------------------------------
// prpc_rsp_if
// Result channel: one allowed bit per range check.
//------------------------------------------------------------------------------
interface prpc_rsp_if;
	logic valid;
	logic ready;
	logic allowed;

	modport source (output valid, allowed, input ready);
	modport sink (input valid, allowed, output ready);
endinterface

FILE: hdl/prpc_cfg_if.sv
//------------------------------------------------------------------------------
// prpc_cfg_if
// Configuration write channel for the region base page register.
//------------------------------------------------------------------------------
interface prpc_cfg_if import prpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BASE_W-1:0] region_base_page;

	modport source (output valid, region_base_page, input ready);
	modport sink (input valid, region_base_page, output ready);
endinterface

FILE: hdl/prpc_ctrl.sv
//------------------------------------------------------------------------------
// prpc_ctrl
// Sequencer for request intake, page walk, drain and result hand-off.
//------------------------------------------------------------------------------
module prpc_ctrl import prpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  prpc_stat_t stat,
	output prpc_cmd_t  cmd
);

	prpc_state_t state_q;
	prpc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (stat.req_valid && stat.req_check) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (stat.over || stat.fail) begin
					state_d = ST_RESULT;
				end else if (stat.rem_zero) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.req_ready = 1'b1;
				cmd.cap       = stat.req_valid && stat.req_check;
				cmd.wr_entry  = stat.req_valid && !stat.req_check;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
			end
			ST_WALK: begin
				// stop issuing as soon as a probe fails
				cmd.clr_ok = stat.over || stat.fail;
				cmd.issue  = !(stat.over || stat.fail);
			end
			ST_DRAIN: begin
				cmd.clr_ok = stat.fail;
			end
			ST_RESULT: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: hdl/prpc_datapath.sv
//------------------------------------------------------------------------------
// prpc_datapath
// Page table storage, range setup arithmetic, page probe and result register.
//------------------------------------------------------------------------------
module prpc_datapath import prpc_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int PAGE_SHIFT    = PAGE_SHIFT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  prpc_cmd_t         cmd,
	output prpc_stat_t        stat,
	input  logic              req_valid,
	input  logic              opcode,
	input  logic [EIDX_W-1:0] entry_index,
	input  logic              entry_valid,
	input  logic [PROT_W-1:0] entry_prot,
	input  logic [ADDR_W-1:0] start_address,
	input  logic [LEN_W-1:0]  byte_length,
	input  logic [PROT_W-1:0] required_prot,
	input  logic              cfg_we,
	input  logic [BASE_W-1:0] cfg_base,
	input  logic              rsp_ready,
	output logic              rsp_valid,
	output logic              allowed
);

	localparam int PN_W  = ADDR_W - PAGE_SHIFT;
	localparam int CW    = ((PN_W > BASE_W) ? PN_W : BASE_W) + 1;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [ADDR_W-1:0] PAGE_ROUND = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

	logic [BASE_W-1:0]        base_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [PROT_W-1:0]        prot_mem [TABLE_ENTRIES];

	logic [ADDR_W-1:0] start_q;
	logic [LEN_W-1:0]  len_q;
	logic [PROT_W-1:0] need_q;
	logic [PN_W-1:0]   cur_page_q;
	logic [PN_W-1:0]   last_page_q;
	logic [CNT_W-1:0]  rem_q;
	logic              over_q;
	logic              ok_q;

	logic              probe_s1;
	logic              inrange_s1;
	logic              valid_s1;
	logic [PROT_W-1:0] prot_s1;

	logic              rsp_valid_q;
	logic              allowed_q;

	// entry write
	logic [IDX_W-1:0] widx;
	logic             widx_ok;

	assign widx    = IDX_W'(entry_index);
	assign widx_ok = 32'(entry_index) < 32'(TABLE_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			valid_q <= '0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_base;
			end
			if (cmd.wr_entry && widx_ok) begin
				valid_q[widx] <= entry_valid;
			end
		end
	end

	// setup arithmetic
	logic [ADDR_W-1:0] round_sum;
	logic [ADDR_W-1:0] steps;
	logic [ADDR_W-1:0] last_addr;

	assign round_sum = {1'b0, len_q} + PAGE_ROUND;
	assign steps     = round_sum >> PAGE_SHIFT;
	assign last_addr = start_q + {1'b0, len_q} - ADDR_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			start_q <= start_address;
			len_q   <= byte_length;
			need_q  <= required_prot;
		end
		if (cmd.setup) begin
			cur_page_q  <= start_q[ADDR_W-1:PAGE_SHIFT];
			last_page_q <= last_addr[ADDR_W-1:PAGE_SHIFT];
			rem_q       <= steps[CNT_W-1:0];
			over_q      <= steps > ADDR_W'(TABLE_ENTRIES);
		end else if (cmd.issue && (rem_q != '0)) begin
			cur_page_q <= cur_page_q + PN_W'(1);
			rem_q      <= rem_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b1;
		end else if (cmd.setup) begin
			ok_q <= 1'b1;
		end else if (cmd.clr_ok) begin
			ok_q <= 1'b0;
		end
	end

	// probe address
	logic [PN_W-1:0]  probe_page;
	logic [CW-1:0]    page_ext;
	logic [CW-1:0]    base_ext;
	logic [CW-1:0]    diff;
	logic             in_range;
	logic [IDX_W-1:0] rel;

	assign probe_page = (rem_q == '0) ? last_page_q : cur_page_q;
	assign page_ext   = CW'(probe_page);
	assign base_ext   = CW'(base_q);
	assign diff       = page_ext - base_ext;
	assign in_range   = (page_ext >= base_ext) && (diff < CW'(TABLE_ENTRIES));
	assign rel        = diff[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.wr_entry && widx_ok) begin
			prot_mem[widx] <= entry_prot;
		end
		if (cmd.issue) begin
			prot_s1    <= prot_mem[rel];
			valid_s1   <= valid_q[rel];
			inrange_s1 <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_s1 <= 1'b0;
		end else begin
			probe_s1 <= cmd.issue;
		end
	end

	logic pass_s1;

	assign pass_s1 = inrange_s1 && valid_s1 && ((prot_s1 & need_q) == need_q);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			allowed_q <= ok_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign allowed   = allowed_q;

	assign stat.req_valid = req_valid;
	assign stat.req_check = (opcode == OP_CHECK);
	assign stat.over      = over_q;
	assign stat.rem_zero  = (rem_q == '0);
	assign stat.fail      = probe_s1 && !pass_s1;
	assign stat.out_free  = !rsp_valid_q || rsp_ready;

endmodule

FILE: hdl/page_range_permission_checker_unit.sv
//------------------------------------------------------------------------------
// page_range_permission_checker_unit
// Page table with valid bit and protection mask per entry; checks that every
// page of a byte range is mapped, inside the region and carries the needed
// protection bits.
//------------------------------------------------------------------------------
//
//  channel  dir  handshake        contents
//  -------  ---  ---------------  ---------------------------------------------
//  req      in   valid/ready      opcode, entry fields, start, length, need mask
//  rsp      out  valid/ready      allowed (one per check request)
//  cfg      in   valid/ready      region_base_page (ready always high)
//
//  A write request updates its entry and leaves the block in intake. A check
//  request goes through setup, walk, drain (skipped when the walk stops early)
//  and result states before intake resumes. The walk probes ceil(length / page
//  size) + 1 pages, fewer when a page fails early, reading one table entry
//  per cycle from the protection memory read port. A range wider than the
//  table fails right after setup, with no probes.
//  Reset clears all valid bits and the base register at once; no clearing pass.
//  A result waiting in the output register does not block new requests; only
//  the next check result waits for the output register to free up.
//
`include "page_range_permission_checker_unit_assert.svh"

module page_range_permission_checker_unit import prpc_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int PAGE_SHIFT    = PAGE_SHIFT_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	prpc_req_if.sink   req,
	prpc_rsp_if.source rsp,
	prpc_cfg_if.sink   cfg
);

	prpc_cmd_t  cmd;
	prpc_stat_t stat;

	// config port never stalls
	assign cfg.ready = 1'b1;
	assign req.ready = cmd.req_ready;

	prpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	prpc_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.PAGE_SHIFT    (PAGE_SHIFT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_valid     (req.valid),
		.opcode        (req.opcode),
		.entry_index   (req.entry_index),
		.entry_valid   (req.entry_valid),
		.entry_prot    (req.entry_prot),
		.start_address (req.start_address),
		.byte_length   (req.byte_length),
		.required_prot (req.required_prot),
		.cfg_we        (cfg.valid),
		.cfg_base      (cfg.region_base_page),
		.rsp_ready     (rsp.ready),
		.rsp_valid     (rsp.valid),
		.allowed       (rsp.allowed)
	);

	// intake and walk never overlap
	`PRPC_ASSERT_SAME(a_no_issue_idle, clk, arst_n, cmd.req_ready, !cmd.issue)
	// a pending result is never overwritten
	`PRPC_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.out_load, !rsp.valid || rsp.ready)
	// loading the result register shows it next cycle
	`PRPC_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.out_load, rsp.valid)
	// an accepted check request takes the block out of intake
	`PRPC_ASSERT_NEXT(a_check_busy, clk, arst_n,
		req.valid && req.ready && (req.opcode == OP_CHECK), !req.ready)

endmodule
